// File: rtl/lfd_pkg.sv
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and constants of the frame deframer
// phase and result codes, register indexes and reset limits
// ----------------------------------------------------------------------------
`default_nettype none

package lfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int FIELD_W     = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MESSAGE_ID  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BODY_LENGTH = 8'd1;

    // limits after reset
    localparam logic [FIELD_W-1:0] RST_MAX_MESSAGE_ID  = 16'd2048;
    localparam logic [FIELD_W-1:0] RST_MAX_BODY_LENGTH = 16'd2048;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DEAD   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BODY       = 2'd0,
        KIND_EMPTY      = 2'd1,
        KIND_BAD_ID     = 2'd2,
        KIND_BAD_LENGTH = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [FIELD_W-1:0]  frame_id;
        logic [FIELD_W-1:0]  frame_length;
        logic [BYTE_W-1:0]   body_byte;
        logic                last_of_frame;
    } t_result;

    typedef struct packed {
        logic [FIELD_W-1:0] max_message_id;
        logic [FIELD_W-1:0] max_body_length;
    } t_limits;

endpackage

`default_nettype wire

// File: rtl/lfd_if.sv
// ----------------------------------------------------------------------------
// lfd_if: channel interfaces of the frame deframer
// byte input, result output and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface lfd_in_if;
    logic                      valid;
    logic                      ready;
    logic [lfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfd_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  result_kind;
    logic [lfd_pkg::FIELD_W-1:0] frame_id;
    logic [lfd_pkg::FIELD_W-1:0] frame_length;
    logic [lfd_pkg::BYTE_W-1:0]  body_byte;
    logic                        last_of_frame;

    modport source (output valid, output result_kind, output frame_id,
                    output frame_length, output body_byte, output last_of_frame,
                    input ready);
    modport sink   (input valid, input result_kind, input frame_id,
                    input frame_length, input body_byte, input last_of_frame,
                    output ready);
endinterface

interface lfd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lfd_pkg::CFG_INDEX_W-1:0] index;
    logic [lfd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/lfd_cfg.sv
// ----------------------------------------------------------------------------
// lfd_cfg: limit registers
// holds the id and length limits, written through the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_cfg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_wr_en,
    input  wire [lfd_pkg::CFG_INDEX_W-1:0] i_wr_index,
    input  wire [lfd_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output lfd_pkg::t_limits o_limits
);

    lfd_pkg::t_limits r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.max_message_id  <= lfd_pkg::RST_MAX_MESSAGE_ID;
            r_limits.max_body_length <= lfd_pkg::RST_MAX_BODY_LENGTH;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                lfd_pkg::CFG_MAX_MESSAGE_ID:  r_limits.max_message_id  <= i_wr_data;
                lfd_pkg::CFG_MAX_BODY_LENGTH: r_limits.max_body_length <= i_wr_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    assign o_limits = r_limits;

endmodule

`default_nettype wire

// File: rtl/lfd_in_reg.sv
// ----------------------------------------------------------------------------
// lfd_in_reg: input byte register
// captures one received byte and holds it until the parser takes it
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_in_reg (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  wire [lfd_pkg::BYTE_W-1:0]  i_byte,
    input  wire                        i_take,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic [lfd_pkg::BYTE_W-1:0] o_byte
);

    logic                       r_valid;
    logic [lfd_pkg::BYTE_W-1:0] r_byte;
    logic                       n_valid;

    // free when empty or drained this cycle
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// File: rtl/lfd_parse.sv
// ----------------------------------------------------------------------------
// lfd_parse: header and body parser
// tracks the framing state and forms the result for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_parse (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_take,
    input  wire [lfd_pkg::BYTE_W-1:0] i_byte,
    input  lfd_pkg::t_limits          i_limits,
    output logic                      o_has_result,
    output lfd_pkg::t_result          o_result
);

    lfd_pkg::t_phase              r_phase, n_phase;
    logic [1:0]                   r_hdr_cnt, n_hdr_cnt;
    logic [23:0]                  r_hdr_shift, n_hdr_shift;
    logic [lfd_pkg::FIELD_W-1:0]  r_cur_id, n_cur_id;
    logic [lfd_pkg::FIELD_W-1:0]  r_cur_len, n_cur_len;
    logic [lfd_pkg::FIELD_W-1:0]  r_left, n_left;
    logic [lfd_pkg::FIELD_W-1:0]  hdr_id, hdr_len;

    assign hdr_id  = r_hdr_shift[23:8];
    assign hdr_len = {r_hdr_shift[7:0], i_byte};

    always_comb begin
        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_hdr_shift  = r_hdr_shift;
        n_cur_id     = r_cur_id;
        n_cur_len    = r_cur_len;
        n_left       = r_left;
        o_has_result = 1'b0;
        o_result.kind          = lfd_pkg::KIND_BODY;
        o_result.frame_id      = r_cur_id;
        o_result.frame_length  = r_cur_len;
        o_result.body_byte     = '0;
        o_result.last_of_frame = 1'b0;

        unique case (r_phase)
            lfd_pkg::PH_HEADER: begin
                if (r_hdr_cnt != 2'd3) begin
                    n_hdr_shift = {r_hdr_shift[15:0], i_byte};
                    n_hdr_cnt   = r_hdr_cnt + 2'd1;
                end else begin
                    n_cur_id              = hdr_id;
                    n_cur_len             = hdr_len;
                    n_hdr_cnt             = 2'd0;
                    n_hdr_shift           = '0;
                    o_result.frame_id     = hdr_id;
                    o_result.frame_length = hdr_len;
                    if (hdr_id > i_limits.max_message_id) begin
                        n_phase       = lfd_pkg::PH_DEAD;
                        o_has_result  = 1'b1;
                        o_result.kind = lfd_pkg::KIND_BAD_ID;
                    end else if (hdr_len > i_limits.max_body_length) begin
                        n_phase       = lfd_pkg::PH_DEAD;
                        o_has_result  = 1'b1;
                        o_result.kind = lfd_pkg::KIND_BAD_LENGTH;
                    end else if (hdr_len == '0) begin
                        o_has_result           = 1'b1;
                        o_result.kind          = lfd_pkg::KIND_EMPTY;
                        o_result.last_of_frame = 1'b1;
                    end else begin
                        n_left  = hdr_len;
                        n_phase = lfd_pkg::PH_BODY;
                    end
                end
            end
            lfd_pkg::PH_BODY: begin
                n_left                 = r_left - 16'd1;
                o_has_result           = 1'b1;
                o_result.body_byte     = i_byte;
                o_result.last_of_frame = (r_left == 16'd1);
                if (r_left == 16'd1) begin
                    n_phase = lfd_pkg::PH_HEADER;
                end
            end
            default: ;  // dead, every byte dropped
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lfd_pkg::PH_HEADER;
            r_hdr_cnt   <= 2'd0;
            r_hdr_shift <= '0;
            r_cur_id    <= '0;
            r_cur_len   <= '0;
            r_left      <= '0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_hdr_shift <= n_hdr_shift;
            r_cur_id    <= n_cur_id;
            r_cur_len   <= n_cur_len;
            r_left      <= n_left;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lfd_out_reg.sv
// ----------------------------------------------------------------------------
// lfd_out_reg: result register
// holds one result until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_out_reg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_load,
    input  lfd_pkg::t_result i_result,
    input  wire              i_ready,
    output logic             o_free,
    output logic             o_valid,
    output lfd_pkg::t_result o_result
);

    logic             r_valid;
    lfd_pkg::t_result r_result;
    logic             n_valid;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: rtl/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer: byte stream deframer with length prefix
// splits a byte stream into frames with a 4-byte id/length header
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  i_rx      in    valid / ready      rx_byte
//  o_res     out   valid / ready      result_kind, frame_id, frame_length,
//                                     body_byte, last_of_frame
//  i_cfg     in    valid / ready      index, data (0 max id, 1 max length)
//
//  one byte a cycle while o_res does not stall: a request is latched in the input
//  register, parsed from it once the result register has room, and its result,
//  if any, lands in the result register
//  reset is synchronous and active low; limits return to 2048 each
//  a stall on o_res backs up through the input register one stage at a time
//  config writes are always accepted
//
`default_nettype none

module length_prefixed_frame_deframer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lfd_in_if.sink     i_rx,
    lfd_out_if.source  o_res,
    lfd_cfg_if.sink    i_cfg
);

    lfd_pkg::t_limits           limits;
    logic                       in_valid;
    logic [lfd_pkg::BYTE_W-1:0] in_byte;
    logic                       out_free;
    logic                       take;
    logic                       has_result;
    lfd_pkg::t_result           result;
    lfd_pkg::t_result           out_result;
    logic                       out_valid;

    // limit registers, a write takes effect in the next cycle
    assign i_cfg.ready = 1'b1;

    lfd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_limits   (limits)
    );

    // the held byte is consumed whenever the result register has room
    assign take = in_valid && out_free;

    lfd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .i_take  (take),
        .o_ready (i_rx.ready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    // framing state advances only on a consumed byte
    lfd_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_byte       (in_byte),
        .i_limits     (limits),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // dead-state bytes and header bytes skip the result register, bar an empty or bad header's last byte
    lfd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && has_result),
        .i_result (result),
        .i_ready  (o_res.ready),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_res.valid         = out_valid;
    assign o_res.result_kind   = out_result.kind;
    assign o_res.frame_id      = out_result.frame_id;
    assign o_res.frame_length  = out_result.frame_length;
    assign o_res.body_byte     = out_result.body_byte;
    assign o_res.last_of_frame = out_result.last_of_frame;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the length-prefixed frame deframer
// feeds byte streams of framed messages through the rx channel, changes the
// id and length limits between phases, tracks the parser state alongside the
// block and compares every result field against the predicted one
// ----------------------------------------------------------------------------

module testbench;

    import lfd_pkg::*;

    // bench timing and sizing
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 4;     // margin for a byte still held in the pipe
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving
    localparam int RANDOM_BYTES   = 400;
    localparam int MAX_WAIT       = 6;

    // register index that maps to nothing, writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'hFF;

    logic i_clk;
    logic i_rst_n;

    lfd_in_if  rx_if ();
    lfd_out_if res_if ();
    lfd_cfg_if cfg_if ();

    length_prefixed_frame_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // shadow of the parser: limits, phase, header gathering and body count
    // ------------------------------------------------------------------------
    t_limits             limits;
    t_phase              parse_phase;
    logic [1:0]          hdr_count;
    logic [23:0]         hdr_shift;
    logic [FIELD_W-1:0]  cur_id;
    logic [FIELD_W-1:0]  cur_len;
    logic [FIELD_W-1:0]  body_left;

    // results still owed by the block, oldest first
    t_result pending_results[$];

    int          mismatches  = 0;
    int unsigned bytes_sent  = 0;

    // idle knobs, each side draws 0..max per request
    int unsigned src_max_gap    = MAX_WAIT;
    int unsigned sink_max_stall = MAX_WAIT;

    function automatic t_result frame_result(t_kind kind, logic [BYTE_W-1:0] data,
                                             logic last);
        t_result r;
        r.kind          = kind;
        r.frame_id      = cur_id;
        r.frame_length  = cur_len;
        r.body_byte     = data;
        r.last_of_frame = last;
        return r;
    endfunction

    // advance the shadow parser by one received byte
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        case (parse_phase)
            PH_HEADER: begin
                if (hdr_count != 2'd3) begin
                    // first three header bytes only shift in
                    hdr_shift = {hdr_shift[15:0], b};
                    hdr_count = hdr_count + 2'd1;
                end else begin
                    cur_id    = hdr_shift[23:8];
                    cur_len   = {hdr_shift[7:0], b};
                    hdr_count = '0;
                    hdr_shift = '0;
                    // id is checked ahead of length
                    if (cur_id > limits.max_message_id) begin
                        parse_phase = PH_DEAD;
                        pending_results.push_back(frame_result(KIND_BAD_ID, '0, 1'b0));
                    end else if (cur_len > limits.max_body_length) begin
                        parse_phase = PH_DEAD;
                        pending_results.push_back(frame_result(KIND_BAD_LENGTH, '0, 1'b0));
                    end else if (cur_len == '0) begin
                        pending_results.push_back(frame_result(KIND_EMPTY, '0, 1'b1));
                    end else begin
                        body_left   = cur_len;
                        parse_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                body_left = body_left - 16'd1;
                if (body_left == '0) begin
                    parse_phase = PH_HEADER;
                end
                pending_results.push_back(frame_result(KIND_BODY, b, body_left == '0));
            end
            default: ;  // dead: everything is dropped until reset
        endcase
    endtask

    // ------------------------------------------------------------------------
    // failure reporting, only the first ten get printed
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure, drawn fresh after every request
    // ------------------------------------------------------------------------
    logic        res_ready = 1'b0;
    int unsigned stall_left = 0;

    assign res_if.ready = res_ready;

    always @(posedge i_clk) begin : result_sink
        int unsigned n;
        if (!i_rst_n) begin
            res_ready  <= 1'b0;
            stall_left <= 0;
        end else if (res_if.valid && res_if.ready) begin
            n = $urandom_range(sink_max_stall, 0);
            stall_left <= n;
            res_ready  <= (n == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            res_ready  <= (stall_left == 1);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // every accepted result is matched against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.kind          = t_kind'(res_if.result_kind);
            got.frame_id      = res_if.frame_id;
            got.frame_length  = res_if.frame_length;
            got.body_byte     = res_if.body_byte;
            got.last_of_frame = res_if.last_of_frame;
            if (pending_results.size() == 0) begin
                note_failure($sformatf(
                    "unexpected result: kind %0d id %h len %h byte %h last %b",
                    got.kind, got.frame_id, got.frame_length, got.body_byte,
                    got.last_of_frame));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    note_failure($sformatf(
                        "result mismatch: got kind %0d id %h len %h byte %h last %b",
                        got.kind, got.frame_id, got.frame_length, got.body_byte,
                        got.last_of_frame));
                    if (mismatches <= 10) begin
                        $display("          expected kind %0d id %h len %h byte %h last %b",
                                 want.kind, want.frame_id, want.frame_length,
                                 want.body_byte, want.last_of_frame);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends a run in which no request moves on any channel
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus primitives
    // ------------------------------------------------------------------------

    // one byte request, with a random gap in front of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = $urandom_range(src_max_gap, 0);
        if (gap != 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // big-endian id then big-endian length
    task automatic send_header(input logic [FIELD_W-1:0] msg_id,
                               input logic [FIELD_W-1:0] body_len);
        send_byte(msg_id[15:8]);
        send_byte(msg_id[7:0]);
        send_byte(body_len[15:8]);
        send_byte(body_len[7:0]);
    endtask

    task automatic send_body(input int unsigned n);
        repeat (n) send_byte(BYTE_W'($urandom_range(255, 0)));
    endtask

    task automatic send_frame(input logic [FIELD_W-1:0] msg_id,
                              input logic [FIELD_W-1:0] body_len);
        send_header(msg_id, body_len);
        send_body(body_len);
    endtask

    // register write; more keeps valid up for a back-to-back write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input bit more);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_MAX_MESSAGE_ID) begin
            limits.max_message_id = value;
        end else if (idx == CFG_MAX_BODY_LENGTH) begin
            limits.max_body_length = value;
        end
        if (!more) begin
            cfg_if.valid <= 1'b0;
        end
    endtask

    task automatic set_limits(input logic [FIELD_W-1:0] max_id,
                              input logic [FIELD_W-1:0] max_len);
        write_reg(CFG_MAX_MESSAGE_ID, max_id, 1'b1);
        write_reg(CFG_MAX_BODY_LENGTH, max_len, 1'b0);
    endtask

    // drain all owed results, then let any byte still in the pipe settle
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // limit for a random phase: all-ones, tiny or anywhere
    function automatic logic [FIELD_W-1:0] pick_limit();
        case ($urandom_range(3, 0))
            0:       return '1;
            1:       return FIELD_W'($urandom_range(16, 0));
            default: return FIELD_W'($urandom_range(65535, 0));
        endcase
    endfunction

    // well-formed frame inside the current limits, short bodies mostly
    task automatic send_random_frame();
        logic [FIELD_W-1:0] msg_id;
        logic [FIELD_W-1:0] body_len;
        int unsigned        cap;
        case ($urandom_range(3, 0))
            0:       msg_id = '0;
            1:       msg_id = limits.max_message_id;
            default: msg_id = FIELD_W'($urandom_range(limits.max_message_id, 0));
        endcase
        cap = ($urandom_range(7, 0) == 0) ? 48 : 12;
        if (limits.max_body_length < cap) begin
            cap = limits.max_body_length;
        end
        if ($urandom_range(5, 0) == 0) begin
            body_len = '0;
        end else begin
            body_len = FIELD_W'($urandom_range(cap, 0));
        end
        send_frame(msg_id, body_len);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset limits: id right at the limit, body bytes at both extremes,
    // then an empty message
    task automatic test_reset_limits();
        send_header(RST_MAX_MESSAGE_ID, 16'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'd0, 16'd0);
    endtask

    // a write to an unmapped index must leave both limits alone
    task automatic test_unmapped_write();
        wait_idle();
        write_reg(CFG_UNUSED_INDEX, 16'h0000, 1'b0);
        send_frame(RST_MAX_MESSAGE_ID, 16'd1);
    endtask

    // both limits at zero: only id 0 with an empty body gets through
    task automatic test_zero_limits();
        wait_idle();
        set_limits(16'd0, 16'd0);
        send_frame(16'd0, 16'd0);
        send_frame(16'd0, 16'd0);
    endtask

    // limits changed while a frame is open between requests
    task automatic test_write_in_frame();
        wait_idle();
        set_limits(16'd50, 16'd1);
        // header paused after three bytes, limits raised, then completed
        send_byte(8'h00);
        send_byte(8'h64);
        send_byte(8'h00);
        wait_idle();
        set_limits(16'd100, 16'd3);
        send_byte(8'h02);
        send_body(2);
        // body already running keeps its length when limits drop to zero
        send_header(16'd7, 16'd3);
        wait_idle();
        set_limits(16'd0, 16'd0);
        send_body(3);
    endtask

    // largest id and a body whose count crosses the low byte, sent back to
    // back with no idling
    task automatic test_largest_frame();
        wait_idle();
        set_limits('1, '1);
        src_max_gap    = 0;
        sink_max_stall = 0;
        send_frame('1, 16'h0100);
        wait_idle();
        src_max_gap    = MAX_WAIT;
        sink_max_stall = MAX_WAIT;
    endtask

    // phases of random frames under random limits and idle settings
    task automatic test_random_frames();
        int unsigned start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            wait_idle();
            set_limits(pick_limit(), pick_limit());
            // some phases run without any idling on one or both sides
            src_max_gap    = ($urandom_range(3, 0) == 0) ? 0 : MAX_WAIT;
            sink_max_stall = ($urandom_range(3, 0) == 0) ? 0 : MAX_WAIT;
            repeat ($urandom_range(12, 4)) send_random_frame();
        end
        src_max_gap    = MAX_WAIT;
        sink_max_stall = MAX_WAIT;
    endtask

    // one fatal header per run, since the block stays dead until reset:
    // bad id, bad length, both bad, or random garbage; then more bytes that
    // must all be dropped
    task automatic test_fatal_header();
        logic [FIELD_W-1:0] msg_id;
        logic [FIELD_W-1:0] body_len;
        wait_idle();
        set_limits(FIELD_W'($urandom_range(4095, 0)), FIELD_W'($urandom_range(4095, 0)));
        case ($urandom_range(3, 0))
            0: begin
                msg_id   = FIELD_W'($urandom_range(65535, limits.max_message_id + 1));
                body_len = FIELD_W'($urandom_range(65535, 0));
                send_header(msg_id, body_len);
            end
            1: begin
                msg_id   = FIELD_W'($urandom_range(limits.max_message_id, 0));
                body_len = FIELD_W'($urandom_range(65535, limits.max_body_length + 1));
                send_header(msg_id, body_len);
            end
            2: begin
                msg_id   = FIELD_W'($urandom_range(65535, limits.max_message_id + 1));
                body_len = FIELD_W'($urandom_range(65535, limits.max_body_length + 1));
                send_header(msg_id, body_len);
            end
            default: begin
                while (parse_phase != PH_DEAD) begin
                    send_byte(BYTE_W'($urandom_range(255, 0)));
                end
            end
        endcase
        send_body(16);
        send_frame(16'd0, 16'd0);
        send_frame(16'd1, 16'd2);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;

        limits.max_message_id  = RST_MAX_MESSAGE_ID;
        limits.max_body_length = RST_MAX_BODY_LENGTH;
        parse_phase = PH_HEADER;
        hdr_count   = '0;
        hdr_shift   = '0;
        cur_id      = '0;
        cur_len     = '0;
        body_left   = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_limits();
        test_unmapped_write();
        test_zero_limits();
        test_write_in_frame();
        test_largest_frame();
        test_random_frames();
        test_fatal_header();
        wait_idle();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/lfd_pkg.sv
rtl/lfd_if.sv
rtl/lfd_cfg.sv
rtl/lfd_in_reg.sv
rtl/lfd_parse.sv
rtl/lfd_out_reg.sv
rtl/length_prefixed_frame_deframer.sv
tb/testbench.sv
